[design/wheel_encoder_gyro_odometry_macros.svh]
// Assertion helpers for the odometry block.
`ifndef WHEEL_ENCODER_GYRO_ODOMETRY_MACROS_SVH
`define WHEEL_ENCODER_GYRO_ODOMETRY_MACROS_SVH

`ifndef SYNTH
`define WEGO_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("%m: assertion failed");
`define WEGO_ASSERT_NEXT(label, clk, rst_n, cond, nxt) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
		else $error("%m: assertion failed");
`else
`define WEGO_ASSERT(label, clk, rst_n, prop)
`define WEGO_ASSERT_NEXT(label, clk, rst_n, cond, nxt)
`endif

`endif

[design/wego_pkg.sv]
package wego_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int ATAN_N = 24;
	localparam int ATAN_IDX_W = 5;

	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam int MUL_W = 27;
	localparam int PROD_W = 2 * MUL_W;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_TICK_TO_METER = 2'd0;
	localparam logic [1:0] REG_WRAP_HIGH = 2'd1;
	localparam logic [1:0] REG_WRAP_LOW = 2'd2;

	localparam logic [15:0] TICK_TO_METER_RST = 16'd1431;
	localparam logic [15:0] WRAP_HIGH_RST = 16'd60000;
	localparam logic [14:0] WRAP_LOW_RST = 15'd1000;

	localparam logic signed [MUL_W-1:0] CORDIC_GAIN = 27'sd10188014;

	// Centidegrees to a 32-bit phase: hr * 2^32 / 36000 splits into an integer
	// part per centidegree and a remainder fraction (hr * 1456 + 1125) / 2250.
	localparam logic signed [17:0] FULL_TURN = 18'sd36000;
	localparam logic [MUL_W-1:0] PHASE_INT = 27'd119304;
	localparam logic [MUL_W-1:0] PHASE_FRAC_NUM = 27'd1456;
	localparam logic [25:0] PHASE_RND = 26'd1125;
	localparam logic [MUL_W-1:0] PHASE_DEN = 27'd2250;
	// floor(2^37 / 2250); the quotient estimate is at most one too small.
	localparam logic [MUL_W-1:0] RECIP_M = 27'd61083979;
	localparam int RECIP_SHIFT = 37;

	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
	localparam logic [31:0] HALF_TURN = 32'h8000_0000;
	localparam logic [31:0] THREE_QUARTER_TURN = 32'hC000_0000;

	localparam logic signed [63:0] ROUND_BIAS = 64'sh0000_0001_0000_0000;

	localparam logic [31:0] ATAN_PHASE [ATAN_N] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	typedef struct packed {
		logic [15:0] tick_to_meter;
		logic [15:0] wrap_high;
		logic [14:0] wrap_low;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic [31:0] phase;
	} cordic_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} cordic_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_MUL_N,
		ST_MUL_BASE,
		ST_MUL_RECIP,
		ST_MUL_CHECK,
		ST_PHASE,
		ST_CORDIC,
		ST_X_LO,
		ST_X_HI,
		ST_Y_LO,
		ST_Y_HI,
		ST_SUM_Y,
		ST_DONE
	} state_t;

	function automatic logic [31:0] atan_phase(input logic [ATAN_IDX_W-1:0] idx);
		logic [31:0] val;
		val = '0;
		if (int'(idx) < ATAN_N) begin
			val = ATAN_PHASE[idx];
		end
		return val;
	endfunction

endpackage

[design/wego_regs.sv]
module wego_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [wego_pkg::ADDR_W-1:0]     paddr,
	input  logic [wego_pkg::DATA_W-1:0]     pwdata,
	output logic [wego_pkg::DATA_W-1:0]     prdata,
	output logic                            pready,
	output wego_pkg::cfg_t                  cfg
);

	localparam int DW = wego_pkg::DATA_W;

	logic wr_en;
	wego_pkg::cfg_t cfg_q;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tick_to_meter <= wego_pkg::TICK_TO_METER_RST;
			cfg_q.wrap_high <= wego_pkg::WRAP_HIGH_RST;
			cfg_q.wrap_low <= wego_pkg::WRAP_LOW_RST;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				wego_pkg::REG_TICK_TO_METER: cfg_q.tick_to_meter <= pwdata[15:0];
				wego_pkg::REG_WRAP_HIGH: cfg_q.wrap_high <= pwdata[15:0];
				wego_pkg::REG_WRAP_LOW: cfg_q.wrap_low <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			wego_pkg::REG_TICK_TO_METER: prdata = DW'(cfg_q.tick_to_meter);
			wego_pkg::REG_WRAP_HIGH: prdata = DW'(cfg_q.wrap_high);
			wego_pkg::REG_WRAP_LOW: prdata = DW'(cfg_q.wrap_low);
			default: prdata = '0;
		endcase
	end

endmodule

[design/wego_mult.sv]
module wego_mult (
	input  logic                                 clk,
	input  logic signed [wego_pkg::MUL_W-1:0]    a,
	input  logic signed [wego_pkg::MUL_W-1:0]    b,
	output logic signed [wego_pkg::PROD_W-1:0]   prod
);

	logic signed [wego_pkg::PROD_W-1:0] prod_q;

	// Shared signed multiplier; every product is registered before use.
	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

	assign prod = prod_q;

endmodule

[design/wego_cordic.sv]
`include "wheel_encoder_gyro_odometry_macros.svh"

module wego_cordic #(
	parameter int STEPS = wego_pkg::CORDIC_STEPS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  wego_pkg::cordic_req_t               req,
	output wego_pkg::cordic_rsp_t               rsp,
	output logic signed [wego_pkg::MUL_W-1:0]   cos_val,
	output logic signed [wego_pkg::MUL_W-1:0]   sin_val
);

	localparam int MW = wego_pkg::MUL_W;
	localparam int IW = wego_pkg::ATAN_IDX_W;
	localparam int CW = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam logic [CW-1:0] LAST = CW'(STEPS - 1);

	logic [CW-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic flip_q;
	logic signed [MW-1:0] x_q;
	logic signed [MW-1:0] y_q;
	logic signed [31:0] z_q;

	logic signed [MW-1:0] x_sh;
	logic signed [MW-1:0] y_sh;
	logic signed [MW-1:0] nx;
	logic signed [MW-1:0] ny;
	logic signed [31:0] nz;
	logic signed [31:0] ang;
	logic last;
	logic flip_d;
	logic [31:0] phase_adj;

	assign last = (cnt_q == LAST);
	assign ang = signed'(wego_pkg::atan_phase(IW'(cnt_q)));
	assign x_sh = x_q >>> cnt_q;
	assign y_sh = y_q >>> cnt_q;

	// Phases in the left half plane are turned by a half turn and the
	// resulting vector negated at the end.
	assign flip_d = (req.phase >= wego_pkg::QUARTER_TURN) &&
		(req.phase < wego_pkg::THREE_QUARTER_TURN);
	assign phase_adj = flip_d ? (req.phase - wego_pkg::HALF_TURN) : req.phase;

	always_comb begin
		if (!z_q[31]) begin
			nx = x_q - y_sh;
			ny = y_q + x_sh;
			nz = z_q - ang;
		end else begin
			nx = x_q + y_sh;
			ny = y_q - x_sh;
			nz = z_q + ang;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.load) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.load) begin
			x_q <= wego_pkg::CORDIC_GAIN;
			y_q <= '0;
			z_q <= signed'(phase_adj);
			flip_q <= flip_d;
		end else if (busy_q) begin
			z_q <= nz;
			if (last && flip_q) begin
				x_q <= -nx;
				y_q <= -ny;
			end else begin
				x_q <= nx;
				y_q <= ny;
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign cos_val = x_q;
	assign sin_val = y_q;

	`WEGO_ASSERT(a_no_load_while_busy, clk, arst_n, !(req.load && busy_q))
	`WEGO_ASSERT(a_done_follows_run, clk, arst_n, !done_q || $past(busy_q))
	`WEGO_ASSERT_NEXT(a_busy_after_load, clk, arst_n, req.load, busy_q)

endmodule

[design/wheel_encoder_gyro_odometry.sv]
// Wheel odometry with gyro heading.
// Sample channel (sample_valid/sample_ready) takes two 16-bit encoder counts
// and a gyro angle in centidegrees; result channel (result_valid/result_ready)
// returns the Q16.16 position and the relative heading, one result per item.
// Registers tick_to_meter, wrap_high and wrap_low sit on the APB port at
// byte addresses 0, 4 and 8; write them only while the block is idle.
// One item is worked on at a time. Its work is the iterative CORDIC, one
// rotation per cycle, plus a chain of products through the single shared
// 27x27 multiplier.
// After reset the position and heading offset are zero; the second item
// after reset zeroes the position and captures its heading as the offset.
// The result sits in an output register. If the receiver stalls, the block
// still accepts and works on the next item, but holds it in its final step
// until the pending result has been taken.
`include "wheel_encoder_gyro_odometry_macros.svh"

module wheel_encoder_gyro_odometry #(
	parameter int CORDIC_STEPS = wego_pkg::CORDIC_STEPS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            sample_valid,
	output logic                            sample_ready,
	input  logic [15:0]                     left_count,
	input  logic [15:0]                     right_count,
	input  logic signed [15:0]              gyro_angle,
	output logic                            result_valid,
	input  logic                            result_ready,
	output logic signed [31:0]              pos_x,
	output logic signed [31:0]              pos_y,
	output logic signed [16:0]              heading,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [wego_pkg::ADDR_W-1:0]     paddr,
	input  logic [wego_pkg::DATA_W-1:0]     pwdata,
	output logic [wego_pkg::DATA_W-1:0]     prdata,
	output logic                            pready
);

	localparam int MW = wego_pkg::MUL_W;
	localparam int RS = wego_pkg::RECIP_SHIFT;

	wego_pkg::state_t state_q;
	wego_pkg::state_t state_d;
	wego_pkg::cfg_t cfg;
	wego_pkg::cordic_req_t cordic_req;
	wego_pkg::cordic_rsp_t cordic_rsp;

	logic [15:0] prev_left_q;
	logic [15:0] prev_right_q;
	logic [31:0] acc_x_q;
	logic [31:0] acc_y_q;
	logic [16:0] offset_q;
	logic captured_q;
	logic [2:0] sample_phase_q;
	logic result_valid_q;

	logic signed [18:0] sum_q;
	logic [16:0] head_q;
	logic [15:0] hr_q;
	logic signed [34:0] dist_q;
	logic [25:0] n_q;
	logic [31:0] base_q;
	logic [14:0] qe_q;
	logic signed [63:0] acc_q;
	logic [31:0] dx_q;
	logic [31:0] dy_q;
	logic signed [31:0] pos_x_q;
	logic signed [31:0] pos_y_q;
	logic signed [16:0] heading_q;

	logic accept;
	logic out_load;
	logic capture;
	logic signed [17:0] dl;
	logic signed [17:0] dr;
	logic [16:0] head_bits;
	logic signed [17:0] h_ext;
	logic signed [17:0] h_add1;
	logic signed [17:0] h_add2;
	logic signed [17:0] h_sub;
	logic [15:0] hr_d;
	logic signed [MW-1:0] mul_a;
	logic signed [MW-1:0] mul_b;
	logic signed [wego_pkg::PROD_W-1:0] prod;
	logic signed [MW-1:0] cos_val;
	logic signed [MW-1:0] sin_val;
	logic signed [MW-1:0] dist_lo;
	logic signed [MW-1:0] dist_hi;
	logic [25:0] rem;
	logic [14:0] q_fix;
	logic [31:0] phase_v;
	logic signed [63:0] p_sum;
	logic [31:0] d_round;
	logic [31:0] new_x;
	logic [31:0] new_y;

	wego_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	wego_mult u_mult (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	wego_cordic #(
		.STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (cordic_req),
		.rsp     (cordic_rsp),
		.cos_val (cos_val),
		.sin_val (sin_val)
	);

	// Tick difference with correction when the count passes the wrap point.
	function automatic logic signed [17:0] wheel_diff(
		input logic [15:0] cur,
		input logic [15:0] prev,
		input logic [15:0] wh,
		input logic [14:0] wl
	);
		logic signed [17:0] d;
		d = signed'({2'b00, cur}) - signed'({2'b00, prev});
		if (prev > wh && cur < {1'b0, wl}) begin
			d = d + 18'sd65536;
		end
		if (prev < {1'b0, wl} && cur > wh) begin
			d = d - 18'sd65536;
		end
		return d;
	endfunction

	assign accept = sample_valid && sample_ready;
	assign dl = wheel_diff(left_count, prev_left_q, cfg.wrap_high, cfg.wrap_low);
	assign dr = wheel_diff(right_count, prev_right_q, cfg.wrap_high, cfg.wrap_low);
	assign head_bits = 17'(gyro_angle) - offset_q;

	// Heading reduced to [0, 36000).
	assign h_ext = 18'(signed'(head_q));
	assign h_add1 = h_ext + wego_pkg::FULL_TURN;
	assign h_add2 = h_add1 + wego_pkg::FULL_TURN;
	assign h_sub = h_ext - wego_pkg::FULL_TURN;

	always_comb begin
		if (h_ext < 0) begin
			hr_d = (h_add1 < 0) ? h_add2[15:0] : h_add1[15:0];
		end else if (h_ext >= wego_pkg::FULL_TURN) begin
			hr_d = h_sub[15:0];
		end else begin
			hr_d = h_ext[15:0];
		end
	end

	// The quotient estimate is corrected by one compare against the divisor.
	assign rem = n_q - prod[25:0];
	assign q_fix = qe_q + 15'(rem >= wego_pkg::PHASE_DEN[25:0]);
	assign phase_v = base_q + 32'(q_fix);

	assign dist_lo = MW'({1'b0, dist_q[17:0]});
	assign dist_hi = MW'(signed'(dist_q[34:18]));

	// The full product is built from two partial products; the bias for
	// round-half-up is already in acc_q.
	assign p_sum = acc_q + (64'(prod) <<< 18);
	assign d_round = {p_sum[63], p_sum[63:33]};

	assign new_x = acc_x_q + dx_q;
	assign new_y = acc_y_q + dy_q;
	assign capture = !captured_q && (sample_phase_q != 3'd0);

	always_comb begin
		state_d = state_q;
		sample_ready = 1'b0;
		out_load = 1'b0;
		mul_a = '0;
		mul_b = '0;
		cordic_req.load = 1'b0;
		cordic_req.phase = phase_v;
		unique case (state_q)
			wego_pkg::ST_IDLE: begin
				sample_ready = 1'b1;
				if (sample_valid) begin
					state_d = wego_pkg::ST_REDUCE;
				end
			end
			wego_pkg::ST_REDUCE: begin
				mul_a = MW'(cfg.tick_to_meter);
				mul_b = MW'(sum_q);
				state_d = wego_pkg::ST_MUL_N;
			end
			wego_pkg::ST_MUL_N: begin
				mul_a = MW'(hr_q);
				mul_b = wego_pkg::PHASE_FRAC_NUM;
				state_d = wego_pkg::ST_MUL_BASE;
			end
			wego_pkg::ST_MUL_BASE: begin
				mul_a = MW'(hr_q);
				mul_b = wego_pkg::PHASE_INT;
				state_d = wego_pkg::ST_MUL_RECIP;
			end
			wego_pkg::ST_MUL_RECIP: begin
				mul_a = MW'(n_q);
				mul_b = wego_pkg::RECIP_M;
				state_d = wego_pkg::ST_MUL_CHECK;
			end
			wego_pkg::ST_MUL_CHECK: begin
				mul_a = MW'(prod[RS+14:RS]);
				mul_b = wego_pkg::PHASE_DEN;
				state_d = wego_pkg::ST_PHASE;
			end
			wego_pkg::ST_PHASE: begin
				cordic_req.load = 1'b1;
				state_d = wego_pkg::ST_CORDIC;
			end
			wego_pkg::ST_CORDIC: begin
				if (cordic_rsp.done) begin
					state_d = wego_pkg::ST_X_LO;
				end
			end
			wego_pkg::ST_X_LO: begin
				mul_a = dist_lo;
				mul_b = cos_val;
				state_d = wego_pkg::ST_X_HI;
			end
			wego_pkg::ST_X_HI: begin
				mul_a = dist_hi;
				mul_b = cos_val;
				state_d = wego_pkg::ST_Y_LO;
			end
			wego_pkg::ST_Y_LO: begin
				mul_a = dist_lo;
				mul_b = sin_val;
				state_d = wego_pkg::ST_Y_HI;
			end
			wego_pkg::ST_Y_HI: begin
				mul_a = dist_hi;
				mul_b = sin_val;
				state_d = wego_pkg::ST_SUM_Y;
			end
			wego_pkg::ST_SUM_Y: begin
				state_d = wego_pkg::ST_DONE;
			end
			wego_pkg::ST_DONE: begin
				if (!result_valid_q || result_ready) begin
					out_load = 1'b1;
					state_d = wego_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = wego_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wego_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_left_q <= '0;
			prev_right_q <= '0;
			acc_x_q <= '0;
			acc_y_q <= '0;
			offset_q <= '0;
			captured_q <= 1'b0;
			sample_phase_q <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				prev_left_q <= left_count;
				prev_right_q <= right_count;
			end
			if (out_load) begin
				result_valid_q <= 1'b1;
				if (capture) begin
					acc_x_q <= '0;
					acc_y_q <= '0;
					offset_q <= head_q;
					captured_q <= 1'b1;
				end else begin
					acc_x_q <= new_x;
					acc_y_q <= new_y;
				end
				sample_phase_q <= (sample_phase_q == 3'd4) ? 3'd0 : sample_phase_q + 3'd1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sum_q <= 19'(dl) + 19'(dr);
			head_q <= head_bits;
		end
		unique case (state_q)
			wego_pkg::ST_REDUCE: hr_q <= hr_d;
			wego_pkg::ST_MUL_N: dist_q <= prod[34:0];
			wego_pkg::ST_MUL_BASE: n_q <= prod[25:0] + wego_pkg::PHASE_RND;
			wego_pkg::ST_MUL_RECIP: base_q <= prod[31:0];
			wego_pkg::ST_MUL_CHECK: qe_q <= prod[RS+14:RS];
			wego_pkg::ST_X_HI: acc_q <= 64'(prod) + wego_pkg::ROUND_BIAS;
			wego_pkg::ST_Y_LO: dx_q <= d_round;
			wego_pkg::ST_Y_HI: acc_q <= 64'(prod) + wego_pkg::ROUND_BIAS;
			wego_pkg::ST_SUM_Y: dy_q <= d_round;
			default: ;
		endcase
		if (out_load) begin
			pos_x_q <= capture ? '0 : signed'(new_x);
			pos_y_q <= capture ? '0 : signed'(new_y);
			heading_q <= signed'(head_q);
		end
	end

	assign result_valid = result_valid_q;
	assign pos_x = pos_x_q;
	assign pos_y = pos_y_q;
	assign heading = heading_q;

	`WEGO_ASSERT(a_phase_range, clk, arst_n, sample_phase_q < 3'd5)
	`WEGO_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, accept, !sample_ready)
	`WEGO_ASSERT_NEXT(a_capture_sticky, clk, arst_n, captured_q, captured_q)
	`WEGO_ASSERT(a_cordic_in_step, clk, arst_n, !cordic_rsp.busy || state_q == wego_pkg::ST_CORDIC)

endmodule

[dv/wheel_encoder_gyro_odometry_tb.sv]
`timescale 1ns / 1ps

module wheel_encoder_gyro_odometry_tb;

	localparam int CORDIC_N = wego_pkg::CORDIC_STEPS_DEF;

	typedef struct packed {
		logic [15:0]        left;
		logic [15:0]        right;
		logic signed [15:0] gyro;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [16:0] heading;
	} pose_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            sample_valid = 1'b0;
	logic                            sample_ready;
	logic [15:0]                     left_count = '0;
	logic [15:0]                     right_count = '0;
	logic signed [15:0]              gyro_angle = '0;
	logic                            result_valid;
	logic                            result_ready = 1'b0;
	logic signed [31:0]              pos_x;
	logic signed [31:0]              pos_y;
	logic signed [16:0]              heading;
	logic                            psel = 1'b0;
	logic                            penable = 1'b0;
	logic                            pwrite = 1'b0;
	logic [wego_pkg::ADDR_W-1:0]     paddr = '0;
	logic [wego_pkg::DATA_W-1:0]     pwdata = '0;
	logic [wego_pkg::DATA_W-1:0]     prdata;
	logic                            pready;

	// Odometry state as the block should hold it.
	wego_pkg::cfg_t cfg_model = '{wego_pkg::TICK_TO_METER_RST, wego_pkg::WRAP_HIGH_RST,
		wego_pkg::WRAP_LOW_RST};
	logic [15:0] prev_l = '0;
	logic [15:0] prev_r = '0;
	logic [31:0] acc_x = '0;
	logic [31:0] acc_y = '0;
	logic [16:0] head_offset = '0;
	logic        origin_set = 1'b0;
	logic [2:0]  sample_cnt = '0;

	sample_t sample_queue[$];
	pose_t   pose_queue[$];
	sample_t next_sample;
	pose_t   want;
	logic [15:0] gen_left = '0;
	logic [15:0] gen_right = '0;
	bit      no_gaps = 1'b0;
	int      n_errors = 0;
	int      n_accepted = 0;
	int      n_checked = 0;
	int      n_wraps = 0;
	int      n_settings = 0;

	wheel_encoder_gyro_odometry #(.CORDIC_STEPS(CORDIC_N)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.left_count(left_count),
		.right_count(right_count),
		.gyro_angle(gyro_angle),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.heading(heading),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int tick_delta(input logic [15:0] cur, input logic [15:0] prev);
		int d;
		d = int'(cur) - int'(prev);
		if (prev > cfg_model.wrap_high && cur < cfg_model.wrap_low) begin
			d += 65536;
			n_wraps++;
		end
		if (prev < cfg_model.wrap_low && cur > cfg_model.wrap_high) begin
			d -= 65536;
			n_wraps++;
		end
		return d;
	endfunction

	// Unit vector along the heading, Q.24, by rotation-mode CORDIC.
	function automatic void heading_vector(input logic signed [16:0] h, output longint c,
		output longint s);
		int          hr;
		logic [63:0] num;
		logic [31:0] ph;
		longint      z;
		longint      x;
		longint      y;
		longint      nx;
		bit          flip;
		hr = int'(h) % 36000;
		if (hr < 0) begin
			hr += 36000;
		end
		num = (64'(hr) << 32) + 64'd18000;
		ph = 32'(num / 64'd36000);
		// The CORDIC only converges within a quarter turn of zero.
		flip = (ph >= wego_pkg::QUARTER_TURN && ph < wego_pkg::THREE_QUARTER_TURN);
		if (flip) begin
			ph = ph - wego_pkg::HALF_TURN;
		end
		z = longint'(signed'(ph));
		x = longint'(wego_pkg::CORDIC_GAIN);
		y = 0;
		for (int i = 0; i < CORDIC_N && i < wego_pkg::ATAN_N; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z = z - longint'(wego_pkg::ATAN_PHASE[i]);
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z = z + longint'(wego_pkg::ATAN_PHASE[i]);
			end
			x = nx;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic logic [31:0] round_q33(input longint p);
		longint t;
		t = (p + 64'sh1_0000_0000) >>> 33;
		return t[31:0];
	endfunction

	function automatic pose_t advance_odometry(input sample_t smp);
		int          dl;
		int          dr;
		longint      travel;
		longint      c;
		longint      s;
		logic [16:0] hbits;
		pose_t       p;
		dl = tick_delta(smp.left, prev_l);
		dr = tick_delta(smp.right, prev_r);
		prev_l = smp.left;
		prev_r = smp.right;
		travel = longint'(cfg_model.tick_to_meter) * longint'(dl + dr);
		hbits = {smp.gyro[15], smp.gyro} - head_offset;
		heading_vector(signed'(hbits), c, s);
		acc_x = acc_x + round_q33(travel * c);
		acc_y = acc_y + round_q33(travel * s);
		// The second sample after reset sets the origin and the heading zero.
		if (!origin_set && sample_cnt != 3'd0) begin
			acc_x = '0;
			acc_y = '0;
			head_offset = hbits;
			origin_set = 1'b1;
		end
		sample_cnt = (sample_cnt == 3'd4) ? 3'd0 : sample_cnt + 3'd1;
		p.x = acc_x;
		p.y = acc_y;
		p.heading = hbits;
		return p;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_valid && sample_ready) begin
				pose_queue.insert(pose_queue.size(), advance_odometry(sample_t'({left_count,
					right_count, gyro_angle})));
				n_accepted++;
			end
			if (!sample_valid || sample_ready) begin
				if (sample_queue.size() != 0 && (no_gaps || $urandom_range(99) >= 24)) begin
					next_sample = sample_queue.pop_front();
					sample_valid <= 1'b1;
					left_count <= next_sample.left;
					right_count <= next_sample.right;
					gyro_angle <= next_sample.gyro;
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			result_ready <= no_gaps || ($urandom_range(99) >= 24);
			if (result_valid && result_ready) begin
				if (pose_queue.size() == 0) begin
					$error("result with no item pending: pos_x %0d pos_y %0d heading %0d",
						pos_x, pos_y, heading);
					n_errors++;
				end else begin
					want = pose_queue.pop_front();
					n_checked++;
					if (pos_x !== want.x) begin
						$error("pos_x: expected %0d, got %0d", want.x, pos_x);
						n_errors++;
					end
					if (pos_y !== want.y) begin
						$error("pos_y: expected %0d, got %0d", want.y, pos_y);
						n_errors++;
					end
					if (heading !== want.heading) begin
						$error("heading: expected %0d, got %0d", want.heading, heading);
						n_errors++;
					end
				end
			end
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			wego_pkg::REG_TICK_TO_METER: cfg_model.tick_to_meter = val[15:0];
			wego_pkg::REG_WRAP_HIGH: cfg_model.wrap_high = val[15:0];
			wego_pkg::REG_WRAP_LOW: cfg_model.wrap_low = val[14:0];
			default: ;
		endcase
		// Read the register back.
		@(posedge clk);
		psel <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== val) begin
			$error("register %0d readback: expected %0d, got %0d", idx, val, prdata);
			n_errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic push_sample(input logic [15:0] l, input logic [15:0] r, input int g);
		sample_t smp;
		smp.left = l;
		smp.right = r;
		smp.gyro = 16'(g);
		sample_queue.insert(sample_queue.size(), smp);
		gen_left = l;
		gen_right = r;
	endtask

	// Mostly a moving robot with random steps, plus counts parked near the
	// wrap and plain noise.
	task automatic queue_random(input int count);
		int mode;
		int l;
		int r;
		int g;
		for (int n = 0; n < count; n++) begin
			mode = $urandom_range(99);
			if (mode < 60) begin
				l = int'(gen_left) + int'($urandom_range(0, 3000)) - 1500;
				r = int'(gen_right) + int'($urandom_range(0, 3000)) - 1500;
			end else if (mode < 80) begin
				l = $urandom_range(1) ? $urandom_range(0, 1500) : $urandom_range(64000, 65535);
				r = $urandom_range(1) ? $urandom_range(0, 1500) : $urandom_range(64000, 65535);
			end else begin
				l = $urandom_range(0, 65535);
				r = $urandom_range(0, 65535);
			end
			mode = $urandom_range(99);
			if (mode < 50) begin
				g = int'($urandom_range(0, 65535)) - 32768;
			end else if (mode < 80) begin
				// Near a multiple of an eighth turn in the relative heading.
				g = int'($urandom_range(0, 13)) * 4500 - 28500 + int'($urandom_range(0, 4)) - 2;
			end else begin
				case ($urandom_range(3))
					0: g = -32768;
					1: g = 32767;
					2: g = 0;
					default: g = -1;
				endcase
			end
			push_sample(16'(l), 16'(r), g);
		end
	endtask

	task automatic drain();
		do
			@(negedge clk);
		while (sample_queue.size() != 0 || sample_valid || pose_queue.size() != 0);
		repeat (CORDIC_N + 14) @(negedge clk);
	endtask

	task automatic run_phase(input logic [15:0] tick, input logic [15:0] hi,
		input logic [14:0] lo, input int count, input bit steady);
		write_reg(wego_pkg::REG_TICK_TO_METER, {16'd0, tick});
		write_reg(wego_pkg::REG_WRAP_HIGH, {16'd0, hi});
		write_reg(wego_pkg::REG_WRAP_LOW, {17'd0, lo});
		n_settings++;
		@(negedge clk);
		no_gaps = steady;
		queue_random(count);
		drain();
		no_gaps = 1'b0;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// The second item captures a heading offset of -60 degrees.
		push_sample(16'd0, 16'd0, -32768);
		push_sample(16'd100, 16'd120, -6000);
		push_sample(16'd65535, 16'd65535, 32767);
		push_sample(16'd200, 16'd300, 3000);
		push_sample(16'd1200, 16'd1300, 21000);
		push_sample(16'd2200, 16'd2000, 12000);
		push_sample(16'd3000, 16'd2500, -15000);
		push_sample(16'd3500, 16'd3600, 30000);
		push_sample(16'd3500, 16'd3600, -6000);
		push_sample(16'd4500, 16'd2500, -32768);
		push_sample(16'd60001, 16'd999, 0);
		push_sample(16'd999, 16'd60001, -1);
		push_sample(16'd1000, 16'd60000, 21845);
		push_sample(16'd65535, 16'd0, -21846);
		push_sample(16'd0, 16'd65535, 4500);
		push_sample(16'd12345, 16'd54321, 2999);
		push_sample(16'd12400, 16'd54300, 3001);
		push_sample(16'd20000, 16'd20000, 20999);
		push_sample(16'd20100, 16'd20050, 21001);
		push_sample(16'd30000, 16'd10000, 11999);
		push_sample(16'd30500, 16'd9500, 12001);
		drain();
		run_phase(16'd65535, 16'd32768, 15'd32767, 300, 1'b1);
		run_phase(16'd0, 16'd65535, 15'd0, 150, 1'b0);
		run_phase(16'd1, 16'd0, 15'd32767, 150, 1'b0);
		repeat (5) begin
			run_phase(16'($urandom_range(1, 65535)), 16'($urandom_range(32768, 65535)),
				15'($urandom_range(0, 32767)), 200, 1'b0);
		end
		$display("Ran %0d samples over %0d register settings plus reset values; %0d checked.",
			n_accepted, n_settings, n_checked);
		$display("Encoder wrap corrections exercised: %0d, with headings across all quadrants.",
			n_wraps);
		if (n_errors == 0) begin
			$display("wheel_encoder_gyro_odometry regression: pass");
		end else begin
			$display("wheel_encoder_gyro_odometry regression: fail");
		end
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#2_000_000;
		$display("wheel_encoder_gyro_odometry regression: fail");
		$finish;
	end

endmodule
